/* rtl/core/vsn_pkg.sv */
// shared constants for the voxel surface normal block
// field widths, register indexes and defaults; no dependencies
`default_nettype none
package vsn_pkg;
    localparam int POS_W       = 6;
    localparam int VAL_W       = 8;
    localparam int NRM_W       = 16;
    localparam int RAD_W       = 2;
    localparam int SIZE_W      = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 7;

    localparam int DEF_MAX_DIM    = 64;
    localparam int DEF_MAX_RADIUS = 3;

    // unit length in q1.14 and the search range for one component
    localparam int ONE_Q   = 16384;
    localparam int Q_W     = 15;
    localparam int Q_SHIFT = 15;
    localparam int TSQ_W   = 2 * Q_W;
    localparam int MUL_W   = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd3;

    localparam logic [RAD_W-1:0]  RADIUS_RST = 2'd1;
    localparam logic [SIZE_W-1:0] SIZE_RST   = 7'd64;
endpackage
`default_nettype wire

/* rtl/core/voxel_surface_normal_top.sv */
// voxel surface normal top level: voxel store, neighborhood scan, shared multiplier
// depends on vsn_pkg and vsn_ram
`default_nettype none
// A load request writes one voxel after the coordinate wrap, which subtracts the
// grid size once per cycle. A compute request scans the 3x3x3 neighborhood one voxel
// a cycle through the single store port, and when that gradient is nonzero scans
// the (2r+1)^3 cube the same way. The three components are then normalized on one
// shared 32x32 multiplier: squares and sum, then a bisection for each component. A
// compute request whose first gradient is zero skips the second scan and the
// bisection. The block takes no request meanwhile. The store needs no clearing after
// reset: every voxel must be loaded before a compute request reads it.
module voxel_surface_normal_top #(
    parameter int MAX_DIM    = vsn_pkg::DEF_MAX_DIM,
    parameter int MAX_RADIUS = vsn_pkg::DEF_MAX_RADIUS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_req_type,
    input  wire logic        [vsn_pkg::POS_W-1:0]  i_pos_x,
    input  wire logic        [vsn_pkg::POS_W-1:0]  i_pos_y,
    input  wire logic        [vsn_pkg::POS_W-1:0]  i_pos_z,
    input  wire logic        [vsn_pkg::VAL_W-1:0]  i_load_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic signed      [vsn_pkg::NRM_W-1:0]  o_normal_x,
    output logic signed      [vsn_pkg::NRM_W-1:0]  o_normal_y,
    output logic signed      [vsn_pkg::NRM_W-1:0]  o_normal_z,
    output logic             [vsn_pkg::VAL_W-1:0]  o_voxel_after,
    output logic                                   o_boundary_flag,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic        [vsn_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [vsn_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int CW   = $clog2(MAX_DIM);
    localparam int SZW  = $clog2(MAX_DIM + 1);
    localparam int RW   = $clog2(MAX_RADIUS + 1);
    localparam int KW   = $clog2(2 * MAX_RADIUS + 1);
    localparam int DW   = KW + 1;
    localparam int VW   = ((vsn_pkg::POS_W > CW) ? vsn_pkg::POS_W : CW) + 2;
    localparam int GMAX = 255 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1)
                          * MAX_RADIUS * (MAX_RADIUS + 1);
    localparam int M    = $clog2(GMAX + 1);
    localparam int GW   = M + 1;
    localparam int H    = M + 1;
    localparam int SW   = 2 * H;
    localparam int SQW  = 2 * M;
    localparam int PW   = vsn_pkg::VAL_W + 1 + DW;
    localparam int LW   = vsn_pkg::TSQ_W + SW + 1;
    localparam int AW   = 3 * CW;
    localparam int PRW  = 2 * vsn_pkg::MUL_W;

    typedef enum logic [3:0] {
        S_IDLE, S_WRAP, S_LOAD, S_SCAN, S_DRAIN, S_POST, S_SQ, S_SQ_ST,
        S_SUM, S_BS_CHK, S_BS_A, S_BS_B, S_BS_C, S_FIN
    } t_state;

    t_state r_state;

    logic [vsn_pkg::RAD_W-1:0]  r_radius;
    logic [vsn_pkg::SIZE_W-1:0] r_size_x, r_size_y, r_size_z;

    logic                       r_load;
    logic [vsn_pkg::VAL_W-1:0]  r_val;
    logic signed [VW-1:0]       r_vx, r_vy, r_vz;
    logic                       r_wrap_start;
    logic                       r_pass;
    logic [RW-1:0]              r_rad;
    logic [CW-1:0]              r_cx, r_cy, r_cz;
    logic [CW-1:0]              r_sx, r_sy, r_sz;
    logic [CW-1:0]              r_ux, r_uy, r_uz;
    logic [KW-1:0]              r_ki, r_kj, r_kk;
    logic                       r_rd_vld;
    logic signed [DW-1:0]       r_rd_dx, r_rd_dy, r_rd_dz;
    logic signed [GW-1:0]       r_gx, r_gy, r_gz;
    logic                       r_solid, r_empty;
    logic [vsn_pkg::VAL_W-1:0]  r_center;
    logic [SQW-1:0]             r_gsq [3];
    logic [SW-1:0]              r_s;
    logic [1:0]                 r_idx;
    logic [vsn_pkg::Q_W-1:0]    r_lo, r_hi, r_mid;
    logic [vsn_pkg::Q_W-1:0]    r_q [3];
    logic [vsn_pkg::TSQ_W-1:0]  r_tsq;
    logic [PRW-1:0]             r_plo;
    logic [PRW-1:0]             r_mul_p;

    logic                       r_o_valid;
    logic signed [vsn_pkg::NRM_W-1:0] r_o_nx, r_o_ny, r_o_nz;
    logic [vsn_pkg::VAL_W-1:0]  r_o_vox;
    logic                       r_o_bnd;

    // effective radius and sizes after saturation
    logic [RW-1:0]  rad_eff;
    logic [SZW-1:0] sx, sy, sz;

    function automatic logic [SZW-1:0] clamp_size(input logic [vsn_pkg::SIZE_W-1:0] v);
        logic [SZW-1:0] res;
        if (v == '0) begin
            res = SZW'(1);
        end else if (int'(v) > MAX_DIM) begin
            res = SZW'(MAX_DIM);
        end else begin
            res = SZW'(v);
        end
        return res;
    endfunction

    always_comb begin
        if (r_radius == '0) begin
            rad_eff = RW'(1);
        end else if (int'(r_radius) > MAX_RADIUS) begin
            rad_eff = RW'(MAX_RADIUS);
        end else begin
            rad_eff = RW'(r_radius);
        end
    end

    assign sx = clamp_size(r_size_x);
    assign sy = clamp_size(r_size_y);
    assign sz = clamp_size(r_size_z);

    // one compare and add or subtract of the size per cycle
    function automatic logic in_rng(input logic signed [VW-1:0] v, input logic [SZW-1:0] s);
        logic signed [VW-1:0] se;
        se = $signed({{(VW - SZW){1'b0}}, s});
        return !v[VW-1] && (v < se);
    endfunction

    function automatic logic signed [VW-1:0] wrap_step(input logic signed [VW-1:0] v,
                                                       input logic [SZW-1:0] s);
        logic signed [VW-1:0] se;
        logic signed [VW-1:0] res;
        se = $signed({{(VW - SZW){1'b0}}, s});
        if (v[VW-1]) begin
            res = v + se;
        end else if (v >= se) begin
            res = v - se;
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [CW-1:0] coord_inc(input logic [CW-1:0] c, input logic [SZW-1:0] s);
        logic [CW:0] nx;
        nx = {1'b0, c} + (CW + 1)'(1);
        return (nx == (CW + 1)'(s)) ? '0 : nx[CW-1:0];
    endfunction

    logic wrap_done;
    assign wrap_done = in_rng(r_vx, sx) && in_rng(r_vy, sy) && in_rng(r_vz, sz);

    // scan cursor
    logic [KW-1:0]        two_r;
    logic signed [DW-1:0] dx, dy, dz;
    logic                 scan_last;
    assign two_r     = KW'({r_rad, 1'b0});
    assign dx        = $signed(DW'(r_ki)) - $signed(DW'(r_rad));
    assign dy        = $signed(DW'(r_kj)) - $signed(DW'(r_rad));
    assign dz        = $signed(DW'(r_kk)) - $signed(DW'(r_rad));
    assign scan_last = (r_ki == two_r) && (r_kj == two_r) && (r_kk == two_r);

    // store port
    logic                      mem_we;
    logic [AW-1:0]             mem_addr;
    logic [vsn_pkg::VAL_W-1:0] mem_wdata;
    logic [vsn_pkg::VAL_W-1:0] rd_data;
    logic                      cleared;

    assign cleared = (r_s == '0) && (!r_solid || r_empty);

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_val;
        mem_addr  = {r_cz, r_cy, r_cx};
        case (r_state)
            S_SCAN: begin
                mem_addr = {r_uz, r_uy, r_ux};
            end
            S_LOAD: begin
                mem_we = 1'b1;
            end
            S_FIN: begin
                mem_we    = cleared;
                mem_wdata = '0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    vsn_ram #(
        .WIDTH (vsn_pkg::VAL_W),
        .DEPTH (2 ** AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (rd_data)
    );

    // gradient contributions of the voxel just read
    logic signed [PW-1:0] prod_x, prod_y, prod_z;
    assign prod_x = $signed({1'b0, rd_data}) * r_rd_dx;
    assign prod_y = $signed({1'b0, rd_data}) * r_rd_dy;
    assign prod_z = $signed({1'b0, rd_data}) * r_rd_dz;

    // shared multiplier operands
    logic signed [GW-1:0]     g_sel;
    logic [M-1:0]             g_abs;
    logic [vsn_pkg::Q_W:0]    mid_sum;
    logic [vsn_pkg::Q_W-1:0]  mid;
    logic [vsn_pkg::Q_W:0]    t_full;
    logic [vsn_pkg::MUL_W-1:0] mul_a, mul_b;

    always_comb begin
        case (r_idx)
            2'd0:    g_sel = r_gx;
            2'd1:    g_sel = r_gy;
            default: g_sel = r_gz;
        endcase
    end

    assign g_abs   = g_sel[GW-1] ? M'(-g_sel) : M'(g_sel);
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi} + (vsn_pkg::Q_W + 1)'(1);
    assign mid     = mid_sum[vsn_pkg::Q_W:1];
    assign t_full  = {mid, 1'b0} - (vsn_pkg::Q_W + 1)'(1);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_SQ: begin
                mul_a = vsn_pkg::MUL_W'(g_abs);
                mul_b = vsn_pkg::MUL_W'(g_abs);
            end
            S_BS_CHK: begin
                mul_a = vsn_pkg::MUL_W'(t_full[vsn_pkg::Q_W-1:0]);
                mul_b = vsn_pkg::MUL_W'(t_full[vsn_pkg::Q_W-1:0]);
            end
            S_BS_A: begin
                mul_a = vsn_pkg::MUL_W'(r_mul_p[vsn_pkg::TSQ_W-1:0]);
                mul_b = vsn_pkg::MUL_W'(r_s[H-1:0]);
            end
            S_BS_B: begin
                mul_a = vsn_pkg::MUL_W'(r_tsq);
                mul_b = vsn_pkg::MUL_W'(r_s[SW-1:H]);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // (2q-1)^2 * s against (2^15 |g|)^2
    logic [LW-1:0] lhs, rhs;
    logic [SQW-1:0] gsq_sel;
    assign gsq_sel = r_gsq[r_idx];
    assign lhs = (LW'(r_mul_p) << H) + LW'(r_plo);
    assign rhs = LW'(gsq_sel) << (2 * vsn_pkg::Q_SHIFT);

    always_ff @(posedge i_clk) begin
        r_mul_p <= mul_a * mul_b;

        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_radius  <= vsn_pkg::RADIUS_RST;
            r_size_x  <= vsn_pkg::SIZE_RST;
            r_size_y  <= vsn_pkg::SIZE_RST;
            r_size_z  <= vsn_pkg::SIZE_RST;
        end else begin
            r_rd_vld <= (r_state == S_SCAN);

            if (r_rd_vld) begin
                r_gx <= r_gx - GW'(prod_x);
                r_gy <= r_gy - GW'(prod_y);
                r_gz <= r_gz - GW'(prod_z);
                if (!r_pass) begin
                    if (rd_data != '0) begin
                        r_solid <= 1'b1;
                    end else begin
                        r_empty <= 1'b1;
                    end
                    if (r_rd_dx == '0 && r_rd_dy == '0 && r_rd_dz == '0) begin
                        r_center <= rd_data;
                    end
                end
            end

            if (r_state == S_FIN && (!r_o_valid || i_out_ready)) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    vsn_pkg::CFG_RADIUS: r_radius <= i_cfg_data[vsn_pkg::RAD_W-1:0];
                    vsn_pkg::CFG_SIZE_X: r_size_x <= i_cfg_data[vsn_pkg::SIZE_W-1:0];
                    vsn_pkg::CFG_SIZE_Y: r_size_y <= i_cfg_data[vsn_pkg::SIZE_W-1:0];
                    vsn_pkg::CFG_SIZE_Z: r_size_z <= i_cfg_data[vsn_pkg::SIZE_W-1:0];
                    default: begin
                    end
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_load       <= !i_req_type;
                        r_val        <= i_load_value;
                        r_vx         <= $signed(VW'(i_pos_x));
                        r_vy         <= $signed(VW'(i_pos_y));
                        r_vz         <= $signed(VW'(i_pos_z));
                        r_wrap_start <= 1'b0;
                        r_pass       <= 1'b0;
                        r_q[0]       <= '0;
                        r_q[1]       <= '0;
                        r_q[2]       <= '0;
                        r_state      <= S_WRAP;
                    end
                end
                S_WRAP: begin
                    if (!wrap_done) begin
                        r_vx <= wrap_step(r_vx, sx);
                        r_vy <= wrap_step(r_vy, sy);
                        r_vz <= wrap_step(r_vz, sz);
                    end else if (!r_wrap_start) begin
                        r_cx <= r_vx[CW-1:0];
                        r_cy <= r_vy[CW-1:0];
                        r_cz <= r_vz[CW-1:0];
                        if (r_load) begin
                            r_state <= S_LOAD;
                        end else begin
                            // first pass over the 3x3x3 neighborhood
                            r_vx         <= r_vx - VW'(1);
                            r_vy         <= r_vy - VW'(1);
                            r_vz         <= r_vz - VW'(1);
                            r_rad        <= RW'(1);
                            r_wrap_start <= 1'b1;
                            r_gx         <= '0;
                            r_gy         <= '0;
                            r_gz         <= '0;
                            r_solid      <= 1'b0;
                            r_empty      <= 1'b0;
                        end
                    end else begin
                        r_sx    <= r_vx[CW-1:0];
                        r_sy    <= r_vy[CW-1:0];
                        r_sz    <= r_vz[CW-1:0];
                        r_ux    <= r_vx[CW-1:0];
                        r_uy    <= r_vy[CW-1:0];
                        r_uz    <= r_vz[CW-1:0];
                        r_ki    <= '0;
                        r_kj    <= '0;
                        r_kk    <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_LOAD: begin
                    r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_rd_dx  <= dx;
                    r_rd_dy  <= dy;
                    r_rd_dz  <= dz;
                    if (scan_last) begin
                        r_state <= S_DRAIN;
                    end else if (r_kk != two_r) begin
                        r_kk <= r_kk + KW'(1);
                        r_uz <= coord_inc(r_uz, sz);
                    end else begin
                        r_kk <= '0;
                        r_uz <= r_sz;
                        if (r_kj != two_r) begin
                            r_kj <= r_kj + KW'(1);
                            r_uy <= coord_inc(r_uy, sy);
                        end else begin
                            r_kj <= '0;
                            r_uy <= r_sy;
                            r_ki <= r_ki + KW'(1);
                            r_ux <= coord_inc(r_ux, sx);
                        end
                    end
                end
                S_DRAIN: begin
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (!r_pass && (r_gx != '0 || r_gy != '0 || r_gz != '0)) begin
                        // second pass over the configured cube
                        r_pass  <= 1'b1;
                        r_rad   <= rad_eff;
                        r_vx    <= $signed(VW'(r_cx)) - $signed(VW'(rad_eff));
                        r_vy    <= $signed(VW'(r_cy)) - $signed(VW'(rad_eff));
                        r_vz    <= $signed(VW'(r_cz)) - $signed(VW'(rad_eff));
                        r_gx    <= '0;
                        r_gy    <= '0;
                        r_gz    <= '0;
                        r_state <= S_WRAP;
                    end else begin
                        r_idx   <= 2'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_SQ_ST;
                end
                S_SQ_ST: begin
                    r_gsq[r_idx] <= r_mul_p[SQW-1:0];
                    if (r_idx == 2'd2) begin
                        r_state <= S_SUM;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_SQ;
                    end
                end
                S_SUM: begin
                    r_s   <= SW'(r_gsq[0]) + SW'(r_gsq[1]) + SW'(r_gsq[2]);
                    r_idx <= 2'd0;
                    r_lo  <= '0;
                    r_hi  <= vsn_pkg::Q_W'(vsn_pkg::ONE_Q);
                    if (r_gx == '0 && r_gy == '0 && r_gz == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_BS_CHK;
                    end
                end
                S_BS_CHK: begin
                    if (r_lo < r_hi) begin
                        r_mid   <= mid;
                        r_state <= S_BS_A;
                    end else begin
                        r_q[r_idx] <= r_lo;
                        r_lo       <= '0;
                        r_hi       <= vsn_pkg::Q_W'(vsn_pkg::ONE_Q);
                        if (r_idx == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                S_BS_A: begin
                    r_tsq   <= r_mul_p[vsn_pkg::TSQ_W-1:0];
                    r_state <= S_BS_B;
                end
                S_BS_B: begin
                    r_plo   <= r_mul_p;
                    r_state <= S_BS_C;
                end
                S_BS_C: begin
                    if (lhs <= rhs) begin
                        r_lo <= r_mid;
                    end else begin
                        r_hi <= r_mid - vsn_pkg::Q_W'(1);
                    end
                    r_state <= S_BS_CHK;
                end
                S_FIN: begin
                    if (!r_o_valid || i_out_ready) begin
                        r_o_nx  <= r_gx[GW-1] ? -vsn_pkg::NRM_W'(r_q[0])
                                              : vsn_pkg::NRM_W'(r_q[0]);
                        r_o_ny  <= r_gy[GW-1] ? -vsn_pkg::NRM_W'(r_q[1])
                                              : vsn_pkg::NRM_W'(r_q[1]);
                        r_o_nz  <= r_gz[GW-1] ? -vsn_pkg::NRM_W'(r_q[2])
                                              : vsn_pkg::NRM_W'(r_q[2]);
                        r_o_vox <= cleared ? '0 : r_center;
                        r_o_bnd <= !cleared && (r_center != '0) && (r_s != '0);
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_o_valid;
    assign o_normal_x      = r_o_nx;
    assign o_normal_y      = r_o_ny;
    assign o_normal_z      = r_o_nz;
    assign o_voxel_after   = r_o_vox;
    assign o_boundary_flag = r_o_bnd;
endmodule
`default_nettype wire

/* rtl/core/vsn_ram.sv */
// generic single port ram with registered read data
// no dependencies
`default_nettype none
module vsn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire
